// File: sv/sdr_pkg.sv
// ----------------------------------------------------------------------------
// sdr_pkg: shared types and constants of the SD SPI block read receiver
// Request and result layouts, mode and status codes, token bytes, block
// geometry and the phase encoding.
// ----------------------------------------------------------------------------
package sdr_pkg;

  // Block geometry
  localparam int BLOCK_BYTES = 512;
  localparam int CRC_BYTES   = 2;

  // Field widths fixed by the interface
  localparam int MODE_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 9;
  localparam int STATUS_W = 3;
  localparam int TICK_W   = 16;
  localparam int CRC_W    = 2;

  // The byte counter covers the block and always the 9-bit index field
  localparam int CNT_W = ($clog2(BLOCK_BYTES) > IDX_W) ? $clog2(BLOCK_BYTES) : IDX_W;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(5000);
  localparam logic [TICK_W-1:0] TICK_MAX      = {TICK_W{1'b1}};

  // Request modes
  localparam logic [MODE_W-1:0] MODE_START_SINGLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START_MULTI  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RX_BYTE      = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TICK         = 2'd3;

  // Card tokens
  localparam logic [BYTE_W-1:0] TOKEN_START   = 8'hFE;
  localparam logic [BYTE_W-1:0] TOKEN_TIMEOUT = 8'h00;
  localparam logic [BYTE_W-1:0] FILLER_BYTE   = 8'hFF;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_IDLE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DATA    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ENDED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FAILED  = 3'd4;

  // Read phase
  typedef enum logic [3:0] {
    PH_WAIT  = 4'b0001,
    PH_DATA  = 4'b0010,
    PH_CRC   = 4'b0100,
    PH_ENDED = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] rx_byte;
  } sdr_in_t;

  typedef struct packed {
    logic                data_valid;
    logic [BYTE_W-1:0]   data_byte;
    logic [IDX_W-1:0]    byte_index;
    logic                last_of_block;
    logic [STATUS_W-1:0] status;
  } sdr_out_t;

endpackage

// File: sv/sd_spi_block_read_receiver.sv
// ----------------------------------------------------------------------------
// sd_spi_block_read_receiver: SD card SPI-mode data block read receiver
// Tracks token wait, payload and check bytes of SD read blocks and emits
// one result per request.
// ----------------------------------------------------------------------------
//
//   channel   signals                        direction
//   in_       in_valid/in_ready, in_data     request: mode, rx_byte
//   out_      out_valid/out_ready, out_data  result: data and status
//   cfg_      cfg_wr_en, cfg_wr_data         token timeout in ticks
//
// One request per cycle sustained while out_ready is high; a result reaches
// out_ through the input register, then the result register.
// Reset (synchronous, rst_n low): read ended, counters zero, timeout 5000.
// While a result waits on out_ready, one more request is held in the input
// register; after that in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module sd_spi_block_read_receiver (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  sdr_pkg::sdr_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output sdr_pkg::sdr_out_t          out_data,
  input  logic                       cfg_wr_en,
  input  logic [sdr_pkg::TICK_W-1:0] cfg_wr_data
);

  logic              item_valid;
  sdr_pkg::sdr_in_t  item_data;
  sdr_pkg::sdr_out_t res;
  logic              can_load;
  logic              advance;

  // Move the held request into the result register when there is room
  assign advance = item_valid && can_load;

  sdr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (advance),
    .item_valid (item_valid),
    .item_data  (item_data)
  );

  sdr_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (advance),
    .item_data   (item_data),
    .res         (res)
  );

  sdr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .load_data (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: sv/sdr_in_reg.sv
// ----------------------------------------------------------------------------
// sdr_in_reg: request input register
// Captures one request and holds it until the core takes it.
// ----------------------------------------------------------------------------
module sdr_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sdr_pkg::sdr_in_t in_data,
  input  logic            take,
  output logic            item_valid,
  output sdr_pkg::sdr_in_t item_data
);

  logic             vld_r;
  logic             vld_nxt;
  sdr_pkg::sdr_in_t data_r;

  // Accept when empty or when the held request leaves this cycle
  assign in_ready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign item_valid = vld_r;
  assign item_data  = data_r;

endmodule

// File: sv/sdr_core.sv
// ----------------------------------------------------------------------------
// sdr_core: read phase tracking and result formation
// Holds the phase, counters and timeout register and forms the result of
// the held request in one pass of logic.
// ----------------------------------------------------------------------------
module sdr_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [sdr_pkg::TICK_W-1:0]    cfg_wr_data,
  input  logic                          step,
  input  sdr_pkg::sdr_in_t              item_data,
  output sdr_pkg::sdr_out_t             res
);

  sdr_pkg::phase_t                  phase_r,   phase_nxt;
  logic [sdr_pkg::CNT_W-1:0]        cnt_r,     cnt_nxt;
  logic [sdr_pkg::CRC_W-1:0]        crc_r,     crc_nxt;
  logic                             multi_r,   multi_nxt;
  logic [sdr_pkg::TICK_W-1:0]       tick_r,    tick_nxt;
  logic [sdr_pkg::TICK_W-1:0]       timeout_r;
  logic [sdr_pkg::TICK_W-1:0]       tick_inc;
  logic [sdr_pkg::CRC_W-1:0]        crc_dec;
  logic                             last_byte;

  assign tick_inc  = (tick_r == sdr_pkg::TICK_MAX) ? tick_r : tick_r + 1'b1;
  assign crc_dec   = (crc_r != '0) ? crc_r - 1'b1 : crc_r;
  assign last_byte = (cnt_r == sdr_pkg::CNT_W'(sdr_pkg::BLOCK_BYTES - 1));

  // Next state and result of the held request
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    multi_nxt = multi_r;
    tick_nxt  = tick_r;
    res       = '0;
    res.status = sdr_pkg::ST_IDLE;

    unique case (item_data.mode)
      sdr_pkg::MODE_START_SINGLE, sdr_pkg::MODE_START_MULTI: begin
        multi_nxt = item_data.mode[0];
        crc_nxt   = '0;
        cnt_nxt   = '0;
        tick_nxt  = '0;
        phase_nxt = sdr_pkg::PH_WAIT;
      end
      sdr_pkg::MODE_TICK: begin
        if (phase_r == sdr_pkg::PH_WAIT) begin
          tick_nxt = tick_inc;
          if (tick_inc > timeout_r) begin
            phase_nxt  = sdr_pkg::PH_ENDED;
            res.status = sdr_pkg::ST_TIMEOUT;
          end
        end
      end
      sdr_pkg::MODE_RX_BYTE: begin
        unique case (phase_r)
          sdr_pkg::PH_WAIT: begin
            if (item_data.rx_byte == sdr_pkg::FILLER_BYTE) begin
              res.status = sdr_pkg::ST_IDLE;
            end else if (item_data.rx_byte == sdr_pkg::TOKEN_START) begin
              phase_nxt = sdr_pkg::PH_DATA;
              cnt_nxt   = '0;
            end else if (item_data.rx_byte == sdr_pkg::TOKEN_TIMEOUT) begin
              phase_nxt  = sdr_pkg::PH_ENDED;
              res.status = sdr_pkg::ST_TIMEOUT;
            end else begin
              phase_nxt  = sdr_pkg::PH_ENDED;
              res.status = sdr_pkg::ST_FAILED;
            end
          end
          sdr_pkg::PH_DATA: begin
            res.data_valid = 1'b1;
            res.data_byte  = item_data.rx_byte;
            res.byte_index = cnt_r[sdr_pkg::IDX_W-1:0];
            res.status     = sdr_pkg::ST_DATA;
            if (last_byte) begin
              res.last_of_block = 1'b1;
              cnt_nxt = '0;
              if (sdr_pkg::CRC_BYTES > 0) begin
                phase_nxt = sdr_pkg::PH_CRC;
                crc_nxt   = sdr_pkg::CRC_W'(sdr_pkg::CRC_BYTES);
              end else begin
                // Block done at once; status stays data
                crc_nxt = '0;
                if (multi_r) begin
                  phase_nxt = sdr_pkg::PH_WAIT;
                  tick_nxt  = '0;
                end else begin
                  phase_nxt = sdr_pkg::PH_ENDED;
                end
              end
            end else begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          sdr_pkg::PH_CRC: begin
            crc_nxt = crc_dec;
            if (crc_dec == '0) begin
              // Last check byte: finish the block
              cnt_nxt = '0;
              if (multi_r) begin
                phase_nxt  = sdr_pkg::PH_WAIT;
                tick_nxt   = '0;
                res.status = sdr_pkg::ST_IDLE;
              end else begin
                phase_nxt  = sdr_pkg::PH_ENDED;
                res.status = sdr_pkg::ST_ENDED;
              end
            end
          end
          sdr_pkg::PH_ENDED: begin
            res.status = sdr_pkg::ST_ENDED;
          end
          default: begin
            res.status = sdr_pkg::ST_ENDED;
          end
        endcase
      end
      default: begin
        res.status = sdr_pkg::ST_IDLE;
      end
    endcase
  end

  // Advance state when the request is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sdr_pkg::PH_ENDED;
      cnt_r   <= '0;
      crc_r   <= '0;
      multi_r <= 1'b0;
      tick_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      multi_r <= multi_nxt;
      tick_r  <= tick_nxt;
    end
  end

  // Timeout register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= sdr_pkg::TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

endmodule

// File: sv/sdr_out_reg.sv
// ----------------------------------------------------------------------------
// sdr_out_reg: result register
// Holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module sdr_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  sdr_pkg::sdr_out_t load_data,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output sdr_pkg::sdr_out_t out_data
);

  logic              vld_r;
  logic              vld_nxt;
  sdr_pkg::sdr_out_t data_r;

  // Room when empty or when the held result is taken this cycle
  assign can_load = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule
